// ===== rtl/hbsd_pkg.sv =====
// Shared types, constants and helpers for the bit-serial Huffman decoder.
`timescale 1ns / 1ps

package hbsd_pkg;

  localparam int MAX_CODE_LEN_DEF = 10;
  localparam int MAX_CODE_LEN_HI  = 16;
  localparam int POS_MAX_W        = MAX_CODE_LEN_HI + 1;

  localparam int CODE_W  = 10;
  localparam int CLEN_W  = 4;
  localparam int SYM_W   = 8;
  localparam int CNT_W   = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] code_bits;
    logic [CLEN_W-1:0] code_length;
    logic [SYM_W-1:0]  symbol_in;
    logic              bit_in;
  } hbsd_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic             overflow;
    logic [CNT_W-1:0] symbols_decoded;
    logic [CNT_W-1:0] bits_consumed;
  } hbsd_out_t;

  typedef struct packed {
    logic                 is_decode;
    logic [POS_MAX_W-1:0] load_pos;
    logic [SYM_W-1:0]     symbol;
    logic                 dbit;
  } hbsd_op_t;

  typedef struct packed {
    logic     valid;
    hbsd_op_t op;
  } hbsd_head_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } hbsd_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/hbsd_front.sv =====
// Front end: accepts input words, drops oversize loads, queues table ops.
`timescale 1ns / 1ps

module hbsd_front #(
  parameter int MAX_CODE_LEN = hbsd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hbsd_pkg::hbsd_in_t   in_word,
  input  hbsd_pkg::hbsd_stat_t stat,
  output hbsd_pkg::hbsd_head_t head
);
  import hbsd_pkg::*;

  localparam logic [CLEN_W:0] MAX_LEN_V = (CLEN_W + 1)'(MAX_CODE_LEN);

  hbsd_op_t            q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  logic                accept;
  logic                keep;
  logic                push;
  logic                pop;
  logic [POS_MAX_W-1:0] lead;
  logic [POS_MAX_W-1:0] code_mask;
  hbsd_op_t            op_new;

  assign in_stall = (cnt_r == QCNT_W'(QUEUE_DEPTH)) || stat.clearing;
  assign accept   = in_valid && !in_stall;
  assign keep     = (in_word.func == FUNC_DECODE) || ({1'b0, in_word.code_length} <= MAX_LEN_V);
  assign push     = accept && keep;
  assign pop      = stat.pop;

  assign lead      = POS_MAX_W'(1) << in_word.code_length;
  assign code_mask = lead - POS_MAX_W'(1);

  always_comb begin
    op_new.is_decode = (in_word.func == FUNC_DECODE);
    op_new.load_pos  = lead | (POS_MAX_W'(in_word.code_bits) & code_mask);
    op_new.symbol    = in_word.symbol_in;
    op_new.dbit      = in_word.bit_in;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_new;
    end
  end

  always_comb begin
    head.valid = (cnt_r != '0);
    head.op    = q_mem_r[rd_ptr_r];
  end

endmodule

// ===== rtl/hbsd_back.sv =====
// Back end: code table memory, tree walk, counters and output register.
`timescale 1ns / 1ps

module hbsd_back #(
  parameter int MAX_CODE_LEN = hbsd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hbsd_pkg::hbsd_head_t head,
  output hbsd_pkg::hbsd_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hbsd_pkg::hbsd_out_t  out_word
);
  import hbsd_pkg::*;

  localparam int ADDR_W      = MAX_CODE_LEN + 1;
  localparam int TABLE_DEPTH = 2 ** ADDR_W;
  localparam logic [ADDR_W-1:0] ROOT_POS = ADDR_W'(1);

  logic [SYM_W:0]      mem [TABLE_DEPTH];
  logic [SYM_W:0]      rdata_r;

  logic                clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;

  logic [ADDR_W-1:0]   pos_r;
  logic [CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]    sym_cnt_r, sym_cnt_nxt;

  logic                r_valid_r;
  logic                r_dec_r;
  logic                r_ovf_r;
  logic [ADDR_W-1:0]   r_next_r;

  logic                out_valid_r, out_valid_nxt;
  hbsd_out_t           out_word_r;

  logic                hit;
  logic                r_has_res;
  logic                out_free;
  logic                r_adv;
  logic                iss_fire;
  logic [ADDR_W-1:0]   pos_eff;
  logic [ADDR_W:0]     next_full;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [SYM_W:0]      wr_data;
  logic                rd_en;

  assign hit       = r_valid_r && r_dec_r && !r_ovf_r && rdata_r[SYM_W];
  assign r_has_res = r_valid_r && r_dec_r && (r_ovf_r || rdata_r[SYM_W]);
  assign out_free  = !out_valid_r || !out_stall;
  assign r_adv     = !r_has_res || out_free;
  assign iss_fire  = head.valid && !clr_busy_r && r_adv;

  assign pos_eff   = (r_valid_r && r_dec_r) ? (r_has_res ? ROOT_POS : r_next_r) : pos_r;
  assign next_full = {pos_eff, head.op.dbit};

  assign rd_en   = iss_fire && head.op.is_decode;
  assign wr_en   = clr_busy_r || (iss_fire && !head.op.is_decode);
  assign wr_addr = clr_busy_r ? clr_cnt_r : head.op.load_pos[ADDR_W-1:0];
  assign wr_data = clr_busy_r ? '0 : {1'b1, head.op.symbol};

  assign stat.clearing = clr_busy_r;
  assign stat.pop      = iss_fire;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[next_full[ADDR_W-1:0]];
    end
  end

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r + ADDR_W'(1);
    clr_busy_nxt = clr_busy_r && (clr_cnt_r != '1);
  end

  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    sym_cnt_nxt = sym_cnt_r;
    if (r_adv && r_valid_r && r_dec_r) begin
      bit_cnt_nxt = sat_inc(bit_cnt_r);
    end
    if (r_adv && hit) begin
      sym_cnt_nxt = sat_inc(sym_cnt_r);
    end
  end

  always_comb begin
    if (r_adv && r_has_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      pos_r       <= ROOT_POS;
      bit_cnt_r   <= '0;
      sym_cnt_r   <= '0;
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
      clr_busy_r  <= clr_busy_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (r_adv) begin
        pos_r     <= pos_eff;
        r_valid_r <= iss_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      r_dec_r  <= head.op.is_decode;
      r_ovf_r  <= next_full[ADDR_W];
      r_next_r <= next_full[ADDR_W-1:0];
    end
    if (r_adv && r_has_res) begin
      out_word_r.symbol_out      <= r_ovf_r ? '0 : rdata_r[SYM_W-1:0];
      out_word_r.overflow        <= r_ovf_r;
      out_word_r.symbols_decoded <= sym_cnt_nxt;
      out_word_r.bits_consumed   <= bit_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assert property (@(posedge clk) disable iff (!rst_n) clr_busy_r |-> !iss_fire)
    else $error("table op issued during clearing pass");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.symbols_decoded <= out_word_r.bits_consumed)
    else $error("symbol count exceeds bit count");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.overflow |-> out_word_r.symbol_out == '0)
    else $error("overflow word carries a symbol");

  assert property (@(posedge clk) disable iff (!rst_n) pos_r != '0)
    else $error("tree position left the table");

  assert property (@(posedge clk) disable iff (!rst_n)
    r_has_res && !out_free |=> $stable(rdata_r))
    else $error("read data lost while result stalled");

endmodule

// ===== rtl/huffman_bit_serial_decoder_unit.sv =====
// Top level of the bit-serial Huffman decoder.
`timescale 1ns / 1ps

// Input channel in_valid/in_stall/in_word: func = load writes a symbol at
// heap position (1 << code_length) | code_bits; func = decode walks the code
// tree by one bit. Loads with code_length above MAX_CODE_LEN are dropped.
// Output channel out_valid/out_stall/out_word: one word per decoded symbol or
// per walk that runs past the table (overflow = 1, symbol 0), carrying both
// saturating counters including the current step.
// Throughput: one input word per cycle while in_stall is low, loads and
// decodes mixed freely; a decode step needs one read of the single-port code
// table memory, and the next tree position is resolved from that read in the
// following cycle. The decode word that completes a symbol goes through the
// input queue, table read register and output register to out_valid.
// Reset: counters clear and the tree returns to the root; then a clearing
// pass over all 2 ** (MAX_CODE_LEN + 1) entries (2048 at the default) empties
// the table while in_stall stays high.
// When out_stall is high the output word holds; up to four input words are
// still queued before in_stall rises.
module huffman_bit_serial_decoder_unit #(
  parameter int MAX_CODE_LEN = hbsd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hbsd_pkg::hbsd_in_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output hbsd_pkg::hbsd_out_t out_word
);
  import hbsd_pkg::*;

  hbsd_head_t head;
  hbsd_stat_t stat;

  hbsd_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .stat     (stat),
    .head     (head)
  );

  hbsd_back #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
